### hdl/swcf_pkg.sv
// Shared types, codes and helpers for the sync word command framer.
`default_nettype none
package swcf_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned CODE_W = 5;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned SMP_W  = 12;
   localparam int unsigned TICK_W = 16;
   localparam int unsigned SPP_W  = 7;
   localparam int unsigned CNT_W  = 8;
   localparam int unsigned IDX_W  = 2;

   localparam logic [WORD_W-1:0] SYNC_MASK = 32'hFFFF_FFE0;
   localparam logic [WORD_W-1:0] SYNC_RESET = 32'h1234_5600;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [SPP_W-1:0]  SPP_RESET = 7'd64;
   localparam logic [SPP_W-1:0]  SPP_MAX = 7'd85;

   typedef enum logic [IDX_W-1:0] {
      REG_SYNC_PATTERN = 2'd0,
      REG_TIMEOUT_MS   = 2'd1,
      REG_SPP          = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DONE        = 3'd0,
      KIND_SAMPLE      = 3'd1,
      KIND_ETH_SET     = 3'd2,
      KIND_UNSUPPORTED = 3'd3,
      KIND_TIMEOUT     = 3'd4
   } event_kind_type;

   localparam logic [CODE_W-1:0] CODE_PACKET  = 5'd0;
   localparam logic [CODE_W-1:0] CODE_ETH_SET = 5'd21;

   typedef struct packed {
      event_kind_type          event_kind;
      logic [CODE_W-1:0]       command_code;
      logic [WORD_W-1:0]       argument_word;
      logic [WORD_W-1:0]       ip_address;
      logic [WORD_W-1:0]       net_mask;
      logic [WORD_W-1:0]       port_number;
      logic [WORD_W-1:0]       gateway_address;
      logic signed [SMP_W-1:0] sample_real;
      logic signed [SMP_W-1:0] sample_imag;
      logic                    last_sample;
   } result_type;

   function automatic logic is_reserved(input logic [CODE_W-1:0] code);
      logic res;
      case (code) inside
         5'd8, [5'd18:5'd20], [5'd23:5'd28], 5'd31: res = 1'b1;
         default: res = 1'b0;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

### hdl/swcf_parser.sv
// Parser state, configuration registers and per-item result logic.
`default_nettype none
module swcf_parser
   import swcf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire logic              item_tick,
   input  wire logic [7:0]        item_byte,
   input  wire logic              csr_we,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [WORD_W-1:0] csr_wdata,
   output logic                   result_valid,
   output result_type             result
);

   logic [WORD_W-1:0] sync_pattern_ff, sync_pattern_in;
   logic [TICK_W-1:0] timeout_ff, timeout_in;
   logic [SPP_W-1:0]  spp_ff, spp_in;

   logic [WORD_W-1:0] window_ff, window_in;
   logic              searching_ff, searching_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic [1:0]        phase_ff, phase_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   logic [WORD_W-1:0] held0_ff, held0_in, held1_ff, held1_in, held2_ff, held2_in;

   logic [WORD_W-1:0] win_shift;
   logic [CNT_W-1:0]  seen_inc;
   logic [1:0]        phase_inc;
   logic [TICK_W-1:0] elapsed_inc;
   logic              sync_hit;
   logic [SPP_W-1:0]  spp_eff;
   logic [CNT_W:0]    packet_len;

   always_comb begin
      sync_pattern_in = sync_pattern_ff;
      timeout_in      = timeout_ff;
      spp_in          = spp_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_SYNC_PATTERN: sync_pattern_in = csr_wdata;
            REG_TIMEOUT_MS:   timeout_in = csr_wdata[TICK_W-1:0];
            REG_SPP:          spp_in = csr_wdata[SPP_W-1:0];
            default: ;
         endcase
      end
   end

   assign win_shift   = {item_byte, window_ff[WORD_W-1:8]};
   assign seen_inc    = (seen_ff == {CNT_W{1'b1}}) ? seen_ff : seen_ff + CNT_W'(1);
   assign phase_inc   = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
   assign elapsed_inc = (elapsed_ff == {TICK_W{1'b1}}) ? elapsed_ff
                                                        : elapsed_ff + TICK_W'(1);
   assign sync_hit    = (win_shift & SYNC_MASK) == (sync_pattern_ff & SYNC_MASK);
   assign spp_eff     = (spp_ff == '0) ? SPP_W'(1) : ((spp_ff > SPP_MAX) ? SPP_MAX : spp_ff);
   assign packet_len  = {1'b0, 1'b0, spp_eff} + {1'b0, spp_eff, 1'b0};

   always_comb begin
      window_in    = window_ff;
      searching_in = searching_ff;
      code_in      = code_ff;
      seen_in      = seen_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      held2_in     = held2_ff;
      result_valid = 1'b0;
      result       = '0;
      result.command_code = code_ff;

      if (item_valid) begin
         if (item_tick) begin
            elapsed_in = elapsed_inc;
            if (!searching_ff && elapsed_inc >= timeout_ff) begin
               result_valid      = 1'b1;
               result.event_kind = KIND_TIMEOUT;
               searching_in      = 1'b1;
            end
         end else begin
            window_in = win_shift;
            seen_in   = seen_inc;
            phase_in  = phase_inc;
            if (searching_ff || is_reserved(code_ff)) begin
               if (!searching_ff) begin
                  result_valid      = 1'b1;
                  result.event_kind = KIND_UNSUPPORTED;
                  searching_in      = 1'b1;
               end
               if (sync_hit) begin
                  searching_in = 1'b0;
                  code_in      = win_shift[CODE_W-1:0];
                  seen_in      = '0;
                  phase_in     = '0;
                  elapsed_in   = '0;
               end
            end else if (code_ff == CODE_PACKET) begin
               if (phase_inc == 2'd0) begin
                  result_valid       = 1'b1;
                  result.event_kind  = KIND_SAMPLE;
                  result.sample_real = win_shift[19:8];
                  result.sample_imag = win_shift[31:20];
                  if ({1'b0, seen_inc} == packet_len) begin
                     result.last_sample = 1'b1;
                     searching_in       = 1'b1;
                  end
               end
            end else if (code_ff == CODE_ETH_SET) begin
               if (seen_inc == CNT_W'(4))  held0_in = win_shift;
               if (seen_inc == CNT_W'(8))  held1_in = win_shift;
               if (seen_inc == CNT_W'(12)) held2_in = win_shift;
               if (seen_inc == CNT_W'(16)) begin
                  result_valid           = 1'b1;
                  result.event_kind      = KIND_ETH_SET;
                  result.ip_address      = held0_ff;
                  result.net_mask        = held1_ff;
                  result.port_number     = held2_ff;
                  result.gateway_address = win_shift;
                  searching_in           = 1'b1;
               end
            end else if (seen_inc == CNT_W'(4)) begin
               result_valid         = 1'b1;
               result.event_kind    = KIND_DONE;
               result.argument_word = win_shift;
               searching_in         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_pattern_ff <= SYNC_RESET;
         timeout_ff      <= TIMEOUT_RESET;
         spp_ff          <= SPP_RESET;
         window_ff       <= '0;
         searching_ff    <= 1'b1;
         code_ff         <= '0;
         seen_ff         <= '0;
         phase_ff        <= '0;
         elapsed_ff      <= '0;
         held0_ff        <= '0;
         held1_ff        <= '0;
         held2_ff        <= '0;
      end else begin
         sync_pattern_ff <= sync_pattern_in;
         timeout_ff      <= timeout_in;
         spp_ff          <= spp_in;
         window_ff       <= window_in;
         searching_ff    <= searching_in;
         code_ff         <= code_in;
         seen_ff         <= seen_in;
         phase_ff        <= phase_in;
         elapsed_ff      <= elapsed_in;
         held0_ff        <= held0_in;
         held1_ff        <= held1_in;
         held2_ff        <= held2_in;
      end
   end

endmodule
`default_nettype wire

### hdl/sync_word_command_framer.sv
// Sync word command framer top level: request channel, parser and result buffer.
//
// The req channel carries one item per transfer: tuser is the action (0 byte,
// 1 millisecond tick) and tdata the received byte. Bytes shift into a 32-bit
// window; a sync word match starts a command whose completion, samples,
// errors and timeouts come out on the rsp channel as single transfers.
// The csr port writes sync_pattern (0), timeout_ms (1) and
// samples_per_packet (2) at any edge with csr_we high; write only when idle.
//
// A result is registered before it is offered on rsp; the skid holds it on a stall.
// Throughput: one request per cycle while req_tready is high; the parser state is
// updated in the accepting cycle, so a following item needs no wait.
// A two-entry result buffer (output register plus skid register) sets the
// stall behaviour: req_tready drops only while both entries are full, so
// one result may wait on a stalled receiver with no loss of rate.
// Reset (synchronous, active high) restores the register defaults, clears
// the window and counters, empties the buffer and starts searching for sync.
`default_nettype none
module sync_word_command_framer
   import swcf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,  // data_byte
   input  wire logic              req_tuser,  // action
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [191:0]           rsp_tdata,  // command_code, argument_word, ip_address,
                                              // net_mask, port_number,
                                              // gateway_address, sample_real,
                                              // sample_imag, zero fill
   output logic [KIND_W-1:0]      rsp_tuser,  // event_kind
   output logic                   rsp_tlast,  // last_sample
   input  wire logic              csr_we,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [WORD_W-1:0] csr_wdata
);

   logic       accept;
   logic       res_valid;
   result_type res;
   logic       push, pop;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   swcf_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (accept),
      .item_tick    (req_tuser),
      .item_byte    (req_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .result_valid (res_valid),
      .result       (res)
   );

   assign push = accept && res_valid;
   assign pop  = main_valid_ff && rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_in       = res;
            skid_valid_in = push;
         end else begin
            main_in       = res;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tuser  = main_ff.event_kind;
   assign rsp_tlast  = main_ff.last_sample;
   assign rsp_tdata  = {3'b000,
                        main_ff.sample_imag,
                        main_ff.sample_real,
                        main_ff.gateway_address,
                        main_ff.port_number,
                        main_ff.net_mask,
                        main_ff.ip_address,
                        main_ff.argument_word,
                        main_ff.command_code};

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking bench for the sync word framer: random and directed byte/tick streams.
`default_nettype none
module testbench
   import swcf_pkg::*;
();

   localparam logic [5:0]  HUNTING        = 6'd32;
   localparam logic [31:0] RESERVED_CODES = 32'h9F9C_0100;
   localparam logic [4:0]  CODE_ORDINARY  = 5'd1;
   localparam logic [4:0]  CODE_RESERVED  = 5'd8;
   localparam int          QUIET_LIMIT    = 2000;

   class framer_scoreboard;
      logic [31:0] sync_word;
      logic [15:0] tick_limit;
      logic [6:0]  packet_len;
      logic [31:0] shift_word;
      logic [5:0]  active_code;
      logic [7:0]  byte_tally;
      logic [15:0] ms_count;
      logic [31:0] eth_words [3];
      result_type  due_events [$];
      int          errors;

      function new();
         sync_word   = SYNC_RESET;
         tick_limit  = TIMEOUT_RESET;
         packet_len  = SPP_RESET;
         shift_word  = '0;
         active_code = HUNTING;
         byte_tally  = '0;
         ms_count    = '0;
         eth_words   = '{default: '0};
         errors      = 0;
      endfunction

      function void write_register(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_SYNC_PATTERN: sync_word = value;
            REG_TIMEOUT_MS: tick_limit = value[15:0];
            REG_SPP: packet_len = value[6:0];
            default: ;
         endcase
      endfunction

      function bit code_reserved(logic [4:0] code);
         return RESERVED_CODES[code];
      endfunction

      function int packet_samples();
         if (packet_len == '0) return 1;
         if (packet_len > SPP_MAX) return SPP_MAX;
         return packet_len;
      endfunction

      function void look_for_sync();
         if ((shift_word & SYNC_MASK) == (sync_word & SYNC_MASK)) begin
            active_code = {1'b0, shift_word[4:0]};
            byte_tally  = '0;
            ms_count    = '0;
         end
      endfunction

      function void accept_item(logic tick, logic [7:0] data_byte);
         result_type ev;
         ev = '0;
         if (tick) begin
            if (ms_count != 16'hFFFF) ms_count++;
            if (active_code == HUNTING || ms_count < tick_limit) return;
            ev.event_kind   = KIND_TIMEOUT;
            ev.command_code = active_code[4:0];
            active_code     = HUNTING;
            due_events.push_back(ev);
            return;
         end
         shift_word = {data_byte, shift_word[31:8]};
         if (byte_tally != 8'hFF) byte_tally++;
         if (active_code == HUNTING) begin
            look_for_sync();
            return;
         end
         ev.command_code = active_code[4:0];
         if (code_reserved(active_code[4:0])) begin
            ev.event_kind = KIND_UNSUPPORTED;
            active_code   = HUNTING;
            look_for_sync();
         end else if (active_code[4:0] == CODE_PACKET) begin
            if (byte_tally % 8'd3 != 0) return;
            ev.event_kind  = KIND_SAMPLE;
            ev.sample_real = shift_word[19:8];
            ev.sample_imag = shift_word[31:20];
            if (byte_tally == 3 * packet_samples()) begin
               ev.last_sample = 1'b1;
               active_code    = HUNTING;
            end
         end else if (active_code[4:0] == CODE_ETH_SET) begin
            case (byte_tally)
               4: eth_words[0] = shift_word;
               8: eth_words[1] = shift_word;
               12: eth_words[2] = shift_word;
               default: ;
            endcase
            if (byte_tally != 16) return;
            ev.event_kind      = KIND_ETH_SET;
            ev.ip_address      = eth_words[0];
            ev.net_mask        = eth_words[1];
            ev.port_number     = eth_words[2];
            ev.gateway_address = shift_word;
            active_code        = HUNTING;
         end else begin
            if (byte_tally != 4) return;
            ev.event_kind    = KIND_DONE;
            ev.argument_word = shift_word;
            active_code      = HUNTING;
         end
         due_events.push_back(ev);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_event(logic [KIND_W-1:0] kind, logic last, logic [191:0] data);
         result_type got, want;
         logic [2:0] fill;
         got.event_kind  = event_kind_type'(kind);
         got.last_sample = last;
         {fill, got.sample_imag, got.sample_real, got.gateway_address, got.port_number,
          got.net_mask, got.ip_address, got.argument_word, got.command_code} = data;
         if (due_events.size() == 0) begin
            $display("%0t: unexpected result, expected none got kind %h", $time, kind);
            errors++;
            return;
         end
         want = due_events.pop_front();
         compare_field("event_kind", want.event_kind, got.event_kind);
         compare_field("command_code", want.command_code, got.command_code);
         compare_field("argument_word", want.argument_word, got.argument_word);
         compare_field("ip_address", want.ip_address, got.ip_address);
         compare_field("net_mask", want.net_mask, got.net_mask);
         compare_field("port_number", want.port_number, got.port_number);
         compare_field("gateway_address", want.gateway_address, got.gateway_address);
         compare_field("sample_real", want.sample_real, got.sample_real);
         compare_field("sample_imag", want.sample_imag, got.sample_imag);
         compare_field("last_sample", want.last_sample, got.last_sample);
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [191:0]  rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic          rsp_tlast;
   logic          csr_we = 1'b0;
   reg_index_type csr_index = REG_SYNC_PATTERN;
   logic [31:0]   csr_wdata = '0;

   framer_scoreboard sb = new();
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;
   int item_count = 0;

   always #1 clock = ~clock;

   sync_word_command_framer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   task automatic send_item(input logic tick, input logic [7:0] data_byte);
      if (!no_idle) begin
         while ($urandom_range(99) < 29) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= tick;
      req_tdata  <= data_byte;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.accept_item(tick, data_byte);
      item_count++;
   endtask

   task automatic start_command(input logic [4:0] code);
      logic [31:0] word;
      word = {sb.sync_word[31:5], code};
      repeat (4) begin
         send_item(1'b0, word[7:0]);
         word = word >> 8;
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.due_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic set_phase(input logic [31:0] sync, input logic [15:0] limit,
                            input logic [6:0] samples);
      wait_idle();
      write_csr(REG_SYNC_PATTERN, sync);
      write_csr(REG_TIMEOUT_MS, {16'h0, limit});
      write_csr(REG_SPP, {25'h0, samples});
      write_csr(REG_UNUSED, $urandom);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sequence();
      int pick;
      int length;
      logic [4:0] code;
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 8)) send_item(1'($urandom), 8'($urandom));
         return;
      end
      if (pick < 35) begin
         code   = CODE_PACKET;
         length = 3 * sb.packet_samples();
      end else if (pick < 50) begin
         code   = CODE_ETH_SET;
         length = 16;
      end else if (pick < 62) begin
         do code = 5'($urandom); while (!sb.code_reserved(code));
         length = 1;
      end else begin
         do code = 5'($urandom);
         while (sb.code_reserved(code) || code == CODE_PACKET || code == CODE_ETH_SET);
         length = 4;
      end
      if ($urandom_range(9) == 0) length = $urandom_range(length - 1);
      start_command(code);
      repeat (length) begin
         if ($urandom_range(99) < 4) send_item(1'b1, 8'($urandom));
         send_item(1'b0, 8'($urandom));
      end
   endtask

   task automatic random_phase(input int count);
      int first;
      first = item_count;
      while (item_count - first < count) send_sequence();
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_event(rsp_tuser, rsp_tlast, rsp_tdata);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || $urandom_range(99) >= 29;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench failed");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_phase(32'hAAAA_AABF, 16'd0, 7'd0);
      start_command(CODE_ORDINARY);
      send_item(1'b1, 8'hFF);
      start_command(CODE_PACKET);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hF8);
      send_item(1'b0, 8'h7F);
      start_command(CODE_PACKET);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h07);
      send_item(1'b0, 8'h80);
      start_command(CODE_ORDINARY);
      repeat (4) send_item(1'b0, 8'hFF);
      start_command(CODE_RESERVED);
      send_item(1'b0, 8'hAA);
      repeat (4) send_item(1'b0, 8'h00);

      set_phase(SYNC_RESET, 16'd100, SPP_MAX);
      hold_request = 1'b1;
      start_command(CODE_PACKET);
      repeat (3 * SPP_MAX) send_item(1'b0, 8'($urandom));
      start_command(CODE_ETH_SET);
      repeat (100) send_item(1'b1, 8'($urandom));
      random_phase(200);

      set_phase($urandom, 16'($urandom_range(1, 20)), 7'($urandom_range(1, 12)));
      random_phase(200);

      no_idle = 1'b1;
      set_phase(SYNC_MASK, 16'd1, 7'd127);
      random_phase(200);
      no_idle = 1'b0;

      set_phase(32'h0, 16'd30, 7'd3);
      random_phase(200);

      set_phase($urandom, 16'd5, 7'($urandom_range(1, 6)));
      random_phase(200);

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.due_events.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
`default_nettype wire
